FILE: rtl/top_k_lowest_denominator_select_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lowest-denominator selector
// Clocked concurrent checks; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TOP_K_LOWEST_DENOMINATOR_SELECT_ASSERT_SVH
`define TOP_K_LOWEST_DENOMINATOR_SELECT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on clk_i, off while rst_ni is low.
`define TKLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define TKLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TKLS_ASSERT(lbl, prop, msg)
`define TKLS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/tkls_pkg.sv
// ----------------------------------------------------------------------------
// tkls_pkg
// Types, sizes and helpers of the lowest-denominator selector.
// ----------------------------------------------------------------------------
package tkls_pkg;

  localparam int MAX_KEEP    = 64;
  localparam int STRING_BITS = 64;
  localparam int KEY_W       = 32;
  localparam int KEEP_W      = 7;
  localparam int IDX_W       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

  // One slot of the chain.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic [STRING_BITS-1:0]  alpha;
    logic [STRING_BITS-1:0]  beta;
  } entry_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic clear;  // drop all slots
    logic shift;  // drain: move every slot one cell up
    logic ins;    // insert the incoming item
  } cell_ctrl_t;

  // Key is -denominator, saturated at the positive end.
  function automatic logic signed [KEY_W-1:0] sat_key(input logic signed [KEY_W-1:0] den);
    logic signed [KEY_W-1:0] res;
    if (den == {1'b1, {(KEY_W-1){1'b0}}}) begin
      res = {1'b0, {(KEY_W-1){1'b1}}};
    end else begin
      res = -den;
    end
    return res;
  endfunction

  // Zero counts as one, anything above the chain length as the chain length.
  function automatic logic [KEEP_W-1:0] clamp_keep(input logic [KEEP_W-1:0] k);
    logic [KEEP_W-1:0] res;
    if (k == '0) begin
      res = KEEP_W'(1);
    end else if (k > KEEP_W'(MAX_KEEP)) begin
      res = KEEP_W'(MAX_KEEP);
    end else begin
      res = k;
    end
    return res;
  endfunction

endpackage

FILE: rtl/tkls_cell.sv
// ----------------------------------------------------------------------------
// tkls_cell
// One slot of the sorted insertion chain.
// ----------------------------------------------------------------------------
module tkls_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tkls_pkg::cell_ctrl_t ctrl_i,
  input  logic               active_i,     // slot index below keep count
  input  tkls_pkg::entry_t   new_i,        // incoming item
  input  tkls_pkg::entry_t   upper_i,      // neighbor one rank higher
  input  logic               upper_take_i, // upper neighbor moves down
  input  tkls_pkg::entry_t   lower_i,      // neighbor one rank lower
  output tkls_pkg::entry_t   slot_o,
  output logic               take_o        // this slot ranks at or below the new item
);
  import tkls_pkg::*;

  entry_t                  slot_q, slot_d;
  logic                    valid_q;
  logic signed [KEY_W-1:0] key_q;
  logic [STRING_BITS-1:0]  alpha_q;
  logic [STRING_BITS-1:0]  beta_q;

  assign slot_q = {valid_q, key_q, alpha_q, beta_q};

  assign take_o = active_i && (!slot_q.valid || (slot_q.key <= new_i.key));
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.clear) begin
      slot_d.valid = 1'b0;
    end else if (ctrl_i.shift) begin
      slot_d = lower_i;
    end else if (ctrl_i.ins && take_o) begin
      if (upper_take_i) begin
        slot_d = upper_i;
      end else begin
        slot_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_d.valid;
    end
  end

  // payload needs no reset: an invalid slot reads as a sentinel
  always_ff @(posedge clk_i) begin
    key_q   <= slot_d.key;
    alpha_q <= slot_d.alpha;
    beta_q  <= slot_d.beta;
  end

endmodule

FILE: rtl/top_k_lowest_denominator_select.sv
// ----------------------------------------------------------------------------
// top_k_lowest_denominator_select
// Streams determinants and keeps the keep_count lowest denominators.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o| denominator_i alpha_string_i beta_string_i
//          |                      | last_item_i
//  out     | out_valid_o/out_ready_i | kept_alpha_o kept_beta_o
//          |                      | kept_denominator_o entry_valid_o last_result_o
//  cfg     | cfg_we_i             | cfg_wdata_i (keep_count)
//
//  One item per cycle while a run streams in: all cells compare in parallel
//  and the chain inserts and shifts in the same cycle.
//  After the last item the chain drains upward through all MAX_KEEP slots;
//  the final keep_count shifts each load one item into the output register.
//  Output stalls freeze the drain once it emits items; in_ready_o is low
//  while draining.
//  Reset (async, active low) leaves keep_count at 10 and all slots empty.
//  A keep_count write empties all slots.
// ----------------------------------------------------------------------------
module top_k_lowest_denominator_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [tkls_pkg::KEEP_W-1:0]         cfg_wdata_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tkls_pkg::KEY_W-1:0]   denominator_i,
  input  logic [tkls_pkg::STRING_BITS-1:0]    alpha_string_i,
  input  logic [tkls_pkg::STRING_BITS-1:0]    beta_string_i,
  input  logic                                last_item_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tkls_pkg::STRING_BITS-1:0]    kept_alpha_o,
  output logic [tkls_pkg::STRING_BITS-1:0]    kept_beta_o,
  output logic signed [tkls_pkg::KEY_W-1:0]   kept_denominator_o,
  output logic                                entry_valid_o,
  output logic                                last_result_o
);
  import tkls_pkg::*;

  `include "top_k_lowest_denominator_select_assert.svh"

  // ---- configuration ------------------------------------------------------
  logic [KEEP_W-1:0] keep_q;
  logic [KEEP_W-1:0] keep_eff;
  logic [KEEP_W-1:0] pre_shift;  // drain shifts before the first emitted item

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KEEP_RESET;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  assign keep_eff  = clamp_keep(keep_q);
  assign pre_shift = KEEP_W'(MAX_KEEP) - keep_eff;

  // ---- drain control ------------------------------------------------------
  logic             drain_q;
  logic [IDX_W-1:0] cnt_q;
  logic             emit_now;
  logic             cnt_last;
  logic             out_free;
  logic             shift;
  logic             in_acc;

  assign in_ready_o = !drain_q;
  assign in_acc     = in_valid_i && in_ready_o;

  assign emit_now = KEEP_W'(cnt_q) >= pre_shift;
  assign cnt_last = cnt_q == IDX_W'(MAX_KEEP - 1);
  assign out_free = !out_valid_o || out_ready_i;
  // slots above keep_count are sentinels and shift out unseen
  assign shift    = drain_q && (!emit_now || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      cnt_q   <= '0;
    end else if (shift) begin
      cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
      if (cnt_last) begin
        drain_q <= 1'b0;
      end
    end else if (in_acc && last_item_i) begin
      drain_q <= 1'b1;
    end
  end

  // ---- insertion chain ----------------------------------------------------
  entry_t     new_entry;
  entry_t     slot   [MAX_KEEP];
  entry_t     upper  [MAX_KEEP];
  entry_t     lower  [MAX_KEEP];
  logic       take   [MAX_KEEP];
  logic       up_take[MAX_KEEP];
  logic       active [MAX_KEEP];
  cell_ctrl_t ctrl;

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = sat_key(denominator_i);
  assign new_entry.alpha = alpha_string_i;
  assign new_entry.beta  = beta_string_i;

  // enter only above the lowest slot; ties keep the older entry
  assign ctrl.ins   = in_acc && (!slot[0].valid || (slot[0].key < new_entry.key));
  assign ctrl.shift = shift;
  assign ctrl.clear = cfg_we_i;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    assign active[i] = KEEP_W'(i) < keep_eff;

    if (i == MAX_KEEP - 1) begin : g_top
      assign upper[i]   = '0;
      assign up_take[i] = 1'b0;
    end else begin : g_mid
      assign upper[i]   = slot[i+1];
      assign up_take[i] = take[i+1];
    end

    if (i == 0) begin : g_bot
      assign lower[i] = '0;  // sentinel shifts in at the bottom
    end else begin : g_up
      assign lower[i] = slot[i-1];
    end

    tkls_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (active[i]),
      .new_i        (new_entry),
      .upper_i      (upper[i]),
      .upper_take_i (up_take[i]),
      .lower_i      (lower[i]),
      .slot_o       (slot[i]),
      .take_o       (take[i])
    );
  end

  // ---- output register ----------------------------------------------------
  entry_t top_slot;
  logic   out_valid_q;
  logic   load;

  assign top_slot = slot[MAX_KEEP-1];
  assign load     = shift && emit_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // sentinels leave with all fields zero
  always_ff @(posedge clk_i) begin
    if (load) begin
      kept_alpha_o       <= top_slot.valid ? top_slot.alpha : '0;
      kept_beta_o        <= top_slot.valid ? top_slot.beta : '0;
      kept_denominator_o <= top_slot.valid ? -top_slot.key : '0;
      entry_valid_o      <= top_slot.valid;
      last_result_o      <= cnt_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---- checks -------------------------------------------------------------
  logic [MAX_KEEP-1:0] slot_valid;
  logic [MAX_KEEP-1:0] order_ok;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_chk
    assign slot_valid[i] = slot[i].valid;
    if (i == MAX_KEEP - 1) begin : g_end
      assign order_ok[i] = 1'b1;
    end else begin : g_pair
      assign order_ok[i] = !(slot[i].valid && slot[i+1].valid) ||
                           (slot[i].key <= slot[i+1].key);
    end
  end

  `TKLS_ASSERT(a_last_starts_drain, (in_acc && last_item_i) |=> drain_q,
               "last item did not start the drain")
  `TKLS_ASSERT(a_drain_end_flags_last, (shift && cnt_last) |=> (out_valid_o && last_result_o),
               "drain ended without the final item flagged")
  `TKLS_ASSERT(a_drain_end_empty, (shift && cnt_last) |=> (slot_valid == '0),
               "slots not empty after drain")
  `TKLS_ASSERT(a_cfg_clears, cfg_we_i |=> (slot_valid == '0),
               "keep_count write did not clear slots")
  `TKLS_ASSERT(a_chain_sorted, &order_ok,
               "slot chain out of order")

endmodule
